@@ src/hrlp_pkg.sv @@
// Shared types, codes and lookup functions for the HTTP request line parser.
`timescale 1ns / 1ps

package hrlp_pkg;

    // Result kinds
    localparam logic [1:0] KIND_PATH    = 2'd0;
    localparam logic [1:0] KIND_VALUE   = 2'd1;
    localparam logic [1:0] KIND_VAL_END = 2'd2;
    localparam logic [1:0] KIND_SUMMARY = 2'd3;

    // MIME codes
    localparam logic [2:0] MIME_NONE = 3'd0;
    localparam logic [2:0] MIME_HTML = 3'd1;
    localparam logic [2:0] MIME_CSS  = 3'd2;
    localparam logic [2:0] MIME_JS   = 3'd3;
    localparam logic [2:0] MIME_JPEG = 3'd4;
    localparam logic [2:0] MIME_PNG  = 3'd5;
    localparam logic [2:0] MIME_ICO  = 3'd6;

    // Characters of interest
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUERY = 8'h3F;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    // Extensions, first character in the low byte
    localparam logic [31:0] EXT_HTML = {"l", "m", "t", "h"};
    localparam logic [31:0] EXT_CSS  = {8'h00, "s", "s", "c"};
    localparam logic [31:0] EXT_JS   = {8'h00, 8'h00, "s", "j"};
    localparam logic [31:0] EXT_JPG  = {8'h00, "g", "p", "j"};
    localparam logic [31:0] EXT_JPEG = {"g", "e", "p", "j"};
    localparam logic [31:0] EXT_PNG  = {8'h00, "g", "n", "p"};
    localparam logic [31:0] EXT_ICO  = {8'h00, "o", "c", "i"};

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic [3:0] param_index;
        logic       is_get;
        logic       path_empty;
        logic       client_side;
        logic [2:0] mime_code;
        logic [4:0] param_count;
        logic       last;
    } res_t;

    // Up to two results caused by one request byte
    typedef struct packed {
        logic has0;
        logic has1;
        res_t r0;
        res_t r1;
    } step_t;

    function automatic logic [7:0] get_char(input logic [1:0] pos);
        logic [7:0] c;
        case (pos)
            2'd0:    c = "G";
            2'd1:    c = "E";
            2'd2:    c = "T";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] mime_lookup(input logic [2:0] len,
                                               input logic [31:0] chars);
        logic [2:0] m;
        m = MIME_NONE;
        if (len == 3'd4 && chars == EXT_HTML)      m = MIME_HTML;
        else if (len == 3'd3 && chars == EXT_CSS)  m = MIME_CSS;
        else if (len == 3'd2 && chars == EXT_JS)   m = MIME_JS;
        else if (len == 3'd3 && chars == EXT_JPG)  m = MIME_JPEG;
        else if (len == 3'd4 && chars == EXT_JPEG) m = MIME_JPEG;
        else if (len == 3'd3 && chars == EXT_PNG)  m = MIME_PNG;
        else if (len == 3'd3 && chars == EXT_ICO)  m = MIME_ICO;
        return m;
    endfunction

endpackage

@@ src/hrlp_core.sv @@
// Parser state and the per-byte step logic producing up to two results.
`timescale 1ns / 1ps

module hrlp_core #(
    parameter int MAX_PATH_LEN = 1023,
    parameter int MAX_PARAMS   = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step_en,
    input  logic [7:0]          req_byte,
    input  logic                first_of_request,
    output hrlp_pkg::step_t     step
);

    localparam int PLW = $clog2(MAX_PATH_LEN + 1);
    localparam int PNW = $clog2(MAX_PARAMS + 2);

    localparam logic [2:0] PH_METHOD = 3'd0;
    localparam logic [2:0] PH_SLASH  = 3'd1;
    localparam logic [2:0] PH_PATH   = 3'd2;
    localparam logic [2:0] PH_QKEY   = 3'd3;
    localparam logic [2:0] PH_QVAL   = 3'd4;
    localparam logic [2:0] PH_SKIP   = 3'd5;
    localparam logic [2:0] PH_DONE   = 3'd6;

    logic [2:0]     phase_reg, phase_next, phase_eff;
    logic           match_reg, match_next, match_eff;
    logic [3:0]     mpos_reg, mpos_next, mpos_eff;
    logic [PLW-1:0] plen_reg, plen_next, plen_eff;
    logic           dot_nz_reg, dot_nz_next, dot_nz_eff;
    logic           dot_seen_reg, dot_seen_next, dot_seen_eff;
    logic [31:0]    ext_reg, ext_next, ext_eff;
    logic [2:0]     elen_reg, elen_next, elen_eff;
    logic [PNW-1:0] pn_reg, pn_next, pn_eff;

    logic [PNW-1:0] pn_inc;
    logic [PNW-1:0] pn_sum;
    logic [PNW-1:0] cnt_sat;
    logic           kept;
    logic           empty;
    hrlp_pkg::res_t summary;
    hrlp_pkg::res_t val_end;

    // A first byte restarts from the reset state
    always_comb
    begin
        if (first_of_request)
        begin
            phase_eff    = PH_METHOD;
            match_eff    = 1'b1;
            mpos_eff     = '0;
            plen_eff     = '0;
            dot_nz_eff   = 1'b0;
            dot_seen_eff = 1'b0;
            ext_eff      = '0;
            elen_eff     = '0;
            pn_eff       = '0;
        end
        else
        begin
            phase_eff    = phase_reg;
            match_eff    = match_reg;
            mpos_eff     = mpos_reg;
            plen_eff     = plen_reg;
            dot_nz_eff   = dot_nz_reg;
            dot_seen_eff = dot_seen_reg;
            ext_eff      = ext_reg;
            elen_eff     = elen_reg;
            pn_eff       = pn_reg;
        end
    end

    assign kept   = (pn_eff < PNW'(MAX_PARAMS));
    assign pn_inc = (pn_eff <= PNW'(MAX_PARAMS)) ? pn_eff + 1'b1 : pn_eff;
    // In the query phases the closing pair is counted before the summary
    assign pn_sum = (phase_eff == PH_QKEY || phase_eff == PH_QVAL) ? pn_inc : pn_eff;
    assign cnt_sat = (pn_sum > PNW'(MAX_PARAMS)) ? PNW'(MAX_PARAMS) : pn_sum;
    assign empty  = (plen_eff == '0);

    always_comb
    begin
        summary      = '0;
        summary.kind = hrlp_pkg::KIND_SUMMARY;
        summary.last = 1'b1;
        if (match_eff)
        begin
            summary.is_get      = 1'b1;
            summary.path_empty  = empty;
            summary.client_side = empty | dot_seen_eff;
            summary.param_count = 5'(cnt_sat);
            if (!empty && plen_eff >= PLW'(3) && dot_seen_eff && dot_nz_eff)
                summary.mime_code = hrlp_pkg::mime_lookup(elen_eff, ext_eff);
        end
        else
        begin
            summary.path_empty  = 1'b1;
            summary.client_side = 1'b1;
        end
    end

    always_comb
    begin
        val_end             = '0;
        val_end.kind        = hrlp_pkg::KIND_VAL_END;
        val_end.param_index = 4'(pn_eff);
    end

    always_comb
    begin
        phase_next    = phase_eff;
        match_next    = match_eff;
        mpos_next     = mpos_eff;
        plen_next     = plen_eff;
        dot_nz_next   = dot_nz_eff;
        dot_seen_next = dot_seen_eff;
        ext_next      = ext_eff;
        elen_next     = elen_eff;
        pn_next       = pn_eff;
        step          = '0;

        case (phase_eff)
            PH_METHOD:
            begin
                if (req_byte == hrlp_pkg::CH_SPACE)
                begin
                    match_next = match_eff && (mpos_eff == 4'd3);
                    phase_next = PH_SLASH;
                end
                else
                begin
                    if (mpos_eff >= 4'd3 || hrlp_pkg::get_char(mpos_eff[1:0]) != req_byte)
                        match_next = 1'b0;
                    if (mpos_eff != 4'd15)
                        mpos_next = mpos_eff + 4'd1;
                end
            end
            PH_SLASH:
            begin
                phase_next = match_eff ? PH_PATH : PH_SKIP;
            end
            PH_SKIP:
            begin
                if (req_byte == hrlp_pkg::CH_SPACE)
                begin
                    step.has0  = 1'b1;
                    step.r0    = summary;
                    phase_next = PH_DONE;
                end
            end
            PH_PATH:
            begin
                if (req_byte == hrlp_pkg::CH_SPACE)
                begin
                    step.has0  = 1'b1;
                    step.r0    = summary;
                    phase_next = PH_DONE;
                end
                else if (req_byte == hrlp_pkg::CH_QUERY)
                begin
                    pn_next    = '0;
                    phase_next = PH_QKEY;
                end
                else if (plen_eff < PLW'(MAX_PATH_LEN))
                begin
                    if (req_byte == hrlp_pkg::CH_DOT)
                    begin
                        dot_nz_next   = !empty;
                        dot_seen_next = 1'b1;
                        ext_next      = '0;
                        elen_next     = '0;
                    end
                    else if (elen_eff < 3'd4)
                    begin
                        // Earlier lanes are already zero past the length
                        ext_next[8*elen_eff[1:0] +: 8] = req_byte;
                        elen_next = elen_eff + 3'd1;
                    end
                    else
                    begin
                        elen_next = 3'd5;
                    end
                    plen_next          = plen_eff + 1'b1;
                    step.has0          = 1'b1;
                    step.r0.kind       = hrlp_pkg::KIND_PATH;
                    step.r0.out_byte   = req_byte;
                end
            end
            PH_QKEY, PH_QVAL:
            begin
                if (req_byte == hrlp_pkg::CH_SPACE || req_byte == hrlp_pkg::CH_AMP)
                begin
                    pn_next = pn_inc;
                    if (kept)
                    begin
                        step.has0 = 1'b1;
                        step.r0   = val_end;
                        if (req_byte == hrlp_pkg::CH_SPACE)
                        begin
                            step.has1 = 1'b1;
                            step.r1   = summary;
                        end
                    end
                    else if (req_byte == hrlp_pkg::CH_SPACE)
                    begin
                        step.has0 = 1'b1;
                        step.r0   = summary;
                    end
                    phase_next = (req_byte == hrlp_pkg::CH_SPACE) ? PH_DONE : PH_QKEY;
                end
                else if (phase_eff == PH_QKEY)
                begin
                    if (req_byte == hrlp_pkg::CH_EQ)
                        phase_next = PH_QVAL;
                end
                else if (kept)
                begin
                    step.has0           = 1'b1;
                    step.r0.kind        = hrlp_pkg::KIND_VALUE;
                    step.r0.out_byte    = req_byte;
                    step.r0.param_index = 4'(pn_eff);
                end
            end
            default:
            begin
                // Drop bytes until the next request starts
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_METHOD;
            match_reg    <= 1'b1;
            mpos_reg     <= '0;
            plen_reg     <= '0;
            dot_nz_reg   <= 1'b0;
            dot_seen_reg <= 1'b0;
            ext_reg      <= '0;
            elen_reg     <= '0;
            pn_reg       <= '0;
        end
        else if (step_en)
        begin
            phase_reg    <= phase_next;
            match_reg    <= match_next;
            mpos_reg     <= mpos_next;
            plen_reg     <= plen_next;
            dot_nz_reg   <= dot_nz_next;
            dot_seen_reg <= dot_seen_next;
            ext_reg      <= ext_next;
            elen_reg     <= elen_next;
            pn_reg       <= pn_next;
        end
    end

    a_pair_shape: assert property (@(posedge clk) disable iff (!rst_n)
        step.has1 |-> (step.has0 && step.r0.kind == hrlp_pkg::KIND_VAL_END
                       && step.r1.kind == hrlp_pkg::KIND_SUMMARY))
        else $error("second result is not a summary after a value end");

    a_done_after_summary: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && step.has0 && step.r0.kind == hrlp_pkg::KIND_SUMMARY)
        |=> (phase_reg == PH_DONE))
        else $error("parser did not finish after a summary");

    a_path_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (plen_reg <= PLW'(MAX_PATH_LEN)) && (pn_reg <= PNW'(MAX_PARAMS + 1)))
        else $error("path length or parameter count past its bound");

endmodule

@@ src/hrlp_out_queue.sv @@
// Result queue: holds step records and hands out their results one at a time.
`timescale 1ns / 1ps

module hrlp_out_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  hrlp_pkg::step_t push_data,
    output logic            full,
    output logic            res_valid,
    input  logic            res_stall,
    output hrlp_pkg::res_t  res
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    hrlp_pkg::step_t  entry_reg [DEPTH];
    logic [AW-1:0]    head_reg, head_next;
    logic [AW-1:0]    tail_reg, tail_next;
    logic [AW:0]      count_reg, count_next;
    logic             sub_reg, sub_next;
    logic             take;
    logic             pop;
    hrlp_pkg::step_t  head_entry;

    assign head_entry = entry_reg[head_reg];
    assign full       = (count_reg == (AW+1)'(DEPTH));
    assign res_valid  = (count_reg != '0);
    assign res        = sub_reg ? head_entry.r1 : head_entry.r0;
    assign take       = res_valid && !res_stall;
    // Advance past the record once its last result leaves
    assign pop        = take && (sub_reg || !head_entry.has1);

    always_comb
    begin
        head_next  = pop ? head_reg + 1'b1 : head_reg;
        tail_next  = push ? tail_reg + 1'b1 : tail_reg;
        sub_next   = take ? !pop : sub_reg;
        count_next = count_reg + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            sub_reg   <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            sub_reg   <= sub_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[tail_reg] <= push_data;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("record pushed into a full queue");

    a_sub_has_second: assert property (@(posedge clk) disable iff (!rst_n)
        sub_reg |-> (res_valid && head_entry.has1))
        else $error("second result selected on a single-result record");

    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count lost a push");

endmodule

@@ src/http_request_line_parser.sv @@
// Top level of the streaming HTTP request line parser.
`timescale 1ns / 1ps

// Channel | Handshake            | Payload
// req     | req_valid/req_stall  | req_byte, first_of_request
// res     | res_valid/res_stall  | kind, out_byte, param_index, is_get, path_empty,
//         |                      | client_side, mime_code, param_count, last
//
// One request byte is taken per cycle while the queue is not full; its results enter
// the result queue at the same edge and are offered once earlier results have left.
// A space closing a kept parameter gives two results (value end, then summary) that leave
// in turn; the four-record result queue absorbs that, so req_stall rises only when full.
// Reset clears the parser state and empties the queue.
// A stall on res holds the offered result; req keeps flowing until the queue fills.
module http_request_line_parser #(
    parameter int MAX_PATH_LEN = 1023,
    parameter int MAX_PARAMS   = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  logic [7:0] req_byte,
    input  logic       first_of_request,
    output logic       res_valid,
    input  logic       res_stall,
    output logic [1:0] kind,
    output logic [7:0] out_byte,
    output logic [3:0] param_index,
    output logic       is_get,
    output logic       path_empty,
    output logic       client_side,
    output logic [2:0] mime_code,
    output logic [4:0] param_count,
    output logic       last
);

    logic            accept;
    logic            full;
    hrlp_pkg::step_t step;
    hrlp_pkg::res_t  res;

    assign req_stall = full;
    assign accept    = req_valid && !full;

    hrlp_core #(
        .MAX_PATH_LEN (MAX_PATH_LEN),
        .MAX_PARAMS   (MAX_PARAMS)
    ) u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .step_en          (accept),
        .req_byte         (req_byte),
        .first_of_request (first_of_request),
        .step             (step)
    );

    hrlp_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && step.has0),
        .push_data (step),
        .full      (full),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    assign kind        = res.kind;
    assign out_byte    = res.out_byte;
    assign param_index = res.param_index;
    assign is_get      = res.is_get;
    assign path_empty  = res.path_empty;
    assign client_side = res.client_side;
    assign mime_code   = res.mime_code;
    assign param_count = res.param_count;
    assign last        = res.last;

endmodule
